[rtl/multi_servo_slew_interpolator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Servo slew interpolator assertion macros
// Shared assertion forms used by the RTL of the servo slew interpolator.
// ----------------------------------------------------------------------------
`ifndef MULTI_SERVO_SLEW_INTERPOLATOR_UNIT_MACROS_SVH
`define MULTI_SERVO_SLEW_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MSI_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MSI_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

[rtl/msi_pkg.sv]
// ----------------------------------------------------------------------------
// msi_pkg
// Types, codes and constants shared by the servo slew interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package msi_pkg;

  localparam int unsigned CHANNELS = 6;
  localparam int unsigned CH_W     = $clog2(CHANNELS);
  localparam int unsigned ANGLE_W  = 14;
  localparam int unsigned OFFSET_W = 15;
  localparam int unsigned STEP_W   = 11;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned PW_W     = 10;
  localparam int unsigned FRAC_W   = 6;
  localparam int unsigned DEG_W    = ANGLE_W - FRAC_W;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // 180 degrees in 1/64 degree
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 14'd11520;

  localparam logic [PW_W-1:0] PULSE_LOW  = 10'd100;
  localparam logic [PW_W-1:0] PULSE_HIGH = 10'd560;
  // 460/180 scaled by 2^16, set slightly high; floor(deg * PULSE_MUL / 2^16) is exact for deg <= 180
  localparam int unsigned     PULSE_MUL_W = 18;
  localparam logic [PULSE_MUL_W-1:0] PULSE_MUL = 18'd167486;
  localparam int unsigned     PROD_W = DEG_W + PULSE_MUL_W;

  localparam logic [ANGLE_W-1:0] NEUTRAL_RESET [CHANNELS] = '{
    14'd5760, 14'd3200, 14'd2240, 14'd5760, 14'd3200, 14'd5440
  };
  localparam logic [STEP_W-1:0] STEP_RESET = 11'd128;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd200;

  // configuration register indexes; neutral angles sit at 0..CHANNELS-1
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 4'd7;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET     = 3'd1,
    CMD_POSE    = 3'd2,
    CMD_NEUTRAL = 3'd3,
    CMD_STATUS  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PULSE  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DONE,
    ST_NEUT
  } state_e;

  typedef enum logic {
    ALU_MOVE,
    ALU_SUM
  } alu_op_e;

  typedef struct packed {
    alu_op_e                     op;
    logic [ANGLE_W-1:0]          lhs;
    logic [ANGLE_W-1:0]          rhs;
    logic signed [OFFSET_W-1:0]  off;
    logic [STEP_W-1:0]           step;
  } alu_req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] value;
    logic               moved;
    logic               arrived;
  } alu_rsp_t;

endpackage

`default_nettype wire

[rtl/msi_alu.sv]
// ----------------------------------------------------------------------------
// msi_alu
// Shared angle unit: one slew step toward a target, or a clamped sum of a
// base angle and a signed offset.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_alu
  import msi_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [STEP_W:0]             step;
  logic signed [ANGLE_W+1:0]   step_s;
  logic signed [ANGLE_W+1:0]   diff;
  logic                        near;
  logic signed [ANGLE_W+2:0]   sum;

  always_comb begin
    // a zero step acts as one
    step   = (req_i.step == '0) ? (STEP_W+1)'(1) : {1'b0, req_i.step};
    step_s = $signed({{(ANGLE_W+1-STEP_W){1'b0}}, step});
    diff   = $signed({2'b00, req_i.rhs}) - $signed({2'b00, req_i.lhs});
    near   = (diff <= step_s) && (diff >= -step_s);
    sum    = $signed({3'b000, req_i.lhs}) + $signed({{2{req_i.off[OFFSET_W-1]}}, req_i.off});

    rsp_o = '0;
    case (req_i.op)
      ALU_MOVE: begin
        rsp_o.moved   = (diff != '0);
        rsp_o.arrived = near;
        if (near) begin
          rsp_o.value = req_i.rhs;
        end else if (diff > 0) begin
          rsp_o.value = req_i.lhs + ANGLE_W'(step);
        end else begin
          rsp_o.value = req_i.lhs - ANGLE_W'(step);
        end
      end
      ALU_SUM: begin
        if (sum < 0) begin
          rsp_o.value = '0;
        end else if (sum > $signed({3'b000, ANGLE_MAX})) begin
          rsp_o.value = ANGLE_MAX;
        end else begin
          rsp_o.value = sum[ANGLE_W-1:0];
        end
      end
      default: rsp_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/multi_servo_slew_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// multi_servo_slew_interpolator_unit
// Six-channel servo slew limiter with kick pose, hold and return to neutral.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_* channel (valid/stall) and results leave on the
//   out_* channel (valid/stall) through one output register. out_last_o marks
//   the final result of a command. Configuration is a plain write port
//   (cfg_we_i, cfg_index_i, cfg_wdata_i); the user must write it only while
//   the block idles, as the block itself does not enforce this. One shared
//   angle unit visits the channels one per cycle under a small sequencer, so
//   the block takes one command at a time and holds in_stall_o high until
//   that command is finished: set target finishes on its transfer; pose,
//   neutral and status visit all six channels; tick scans all six channels,
//   then loads one result per moved channel up to the last one moved, then,
//   when a kick hold ends, a done result and a neutral sweep.
//   The first pulse result of a tick is loaded after the scan.
//   A stalled receiver freezes the sequencer on the next result to load; the
//   scan and the neutral sweep do not wait on the output.
//   Reset puts angles and targets at the neutral reset values, clears the kick
//   and hold state and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_servo_slew_interpolator_unit_macros.svh"

module multi_servo_slew_interpolator_unit
  import msi_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata_i,

  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  in_command_i,
  input  wire logic [3:0]                  in_channel_i,
  input  wire logic [ANGLE_W-1:0]          in_target_i,
  input  wire logic signed [OFFSET_W-1:0]  in_offset_0_i,
  input  wire logic signed [OFFSET_W-1:0]  in_offset_1_i,
  input  wire logic signed [OFFSET_W-1:0]  in_offset_2_i,
  input  wire logic signed [OFFSET_W-1:0]  in_offset_3_i,
  input  wire logic signed [OFFSET_W-1:0]  in_offset_4_i,
  input  wire logic signed [OFFSET_W-1:0]  in_offset_5_i,

  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       out_kind_o,
  output logic [2:0]                       out_servo_o,
  output logic [PW_W-1:0]                  out_pulse_width_o,
  output logic [ANGLE_W-1:0]               out_position_o,
  output logic                             out_last_o
);

  // configuration
  logic [ANGLE_W-1:0] neutral_q [CHANNELS];
  logic [STEP_W-1:0]  step_q;
  logic [HOLD_W-1:0]  hold_ticks_q;

  // servo state
  logic [ANGLE_W-1:0] cur_q [CHANNELS];
  logic [ANGLE_W-1:0] tgt_q [CHANNELS];
  logic signed [OFFSET_W-1:0] off_q [CHANNELS];
  logic               kick_q, kick_d;
  logic               hold_q, hold_d;
  logic [HOLD_W-1:0]  hold_cnt_q, hold_cnt_d;

  // sequencer
  state_e             state_q, state_d;
  logic [CH_W-1:0]    idx_q, idx_d;
  logic [CHANNELS-1:0] mask_q, mask_d;
  logic               all_at_q, all_at_d;
  logic               done_q, done_d;
  logic               use_off_q, use_off_d;
  kind_e              emit_kind_q, emit_kind_d;

  // output register
  logic               out_valid_q;
  kind_e              out_kind_q, out_kind_d;
  logic [CH_W-1:0]    out_servo_q, out_servo_d;
  logic [PW_W-1:0]    out_pw_q, out_pw_d;
  logic [ANGLE_W-1:0] out_pos_q, out_pos_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               can_load;

  // datapath
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               cur_we;
  logic               tgt_we;
  logic [CH_W-1:0]    tgt_idx;
  logic               in_xfer;
  logic               at_all;
  logic               hold_n;
  logic [HOLD_W-1:0]  cnt_n;
  logic [CHANNELS-1:0] above;
  logic [DEG_W-1:0]   deg;
  logic [PROD_W-1:0]  prod;
  logic [PW_W-1:0]    pulse;

  msi_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign above      = mask_q >> (idx_q + CH_W'(1));

  // pulse = low + floor(deg * 460 / 180)
  assign deg   = cur_q[idx_q][ANGLE_W-1:FRAC_W];
  assign prod  = PROD_W'(deg) * PROD_W'(PULSE_MUL);
  assign pulse = PULSE_LOW + prod[PROD_W-1:16];

  // operand select for the shared unit
  always_comb begin
    alu_req      = '0;
    alu_req.step = step_q;
    case (state_q)
      ST_IDLE: begin
        alu_req.op  = ALU_SUM;
        alu_req.lhs = in_target_i;
      end
      ST_SCAN: begin
        alu_req.op  = ALU_MOVE;
        alu_req.lhs = cur_q[idx_q];
        alu_req.rhs = tgt_q[idx_q];
      end
      ST_NEUT: begin
        alu_req.op  = ALU_SUM;
        alu_req.lhs = neutral_q[idx_q];
        alu_req.off = use_off_q ? off_q[idx_q] : '0;
      end
      default: alu_req.op = ALU_SUM;
    endcase
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mask_d      = mask_q;
    all_at_d    = all_at_q;
    done_d      = done_q;
    use_off_d   = use_off_q;
    emit_kind_d = emit_kind_q;
    kick_d      = kick_q;
    hold_d      = hold_q;
    hold_cnt_d  = hold_cnt_q;
    cur_we      = 1'b0;
    tgt_we      = 1'b0;
    tgt_idx     = idx_q;
    out_load    = 1'b0;
    out_kind_d  = KIND_PULSE;
    out_servo_d = idx_q;
    out_pw_d    = '0;
    out_pos_d   = '0;
    out_last_d  = 1'b0;
    at_all      = all_at_q && alu_rsp.arrived;
    hold_n      = hold_q;
    cnt_n       = hold_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (cmd_e'(in_command_i))
            CMD_TICK: begin
              state_d  = ST_SCAN;
              idx_d    = '0;
              mask_d   = '0;
              all_at_d = 1'b1;
            end
            CMD_SET: begin
              tgt_idx = in_channel_i[CH_W-1:0];
              tgt_we  = (in_channel_i < 4'(CHANNELS));
            end
            CMD_POSE: begin
              kick_d     = 1'b1;
              hold_d     = 1'b0;
              hold_cnt_d = '0;
              use_off_d  = 1'b1;
              idx_d      = '0;
              state_d    = ST_NEUT;
            end
            CMD_NEUTRAL: begin
              kick_d     = 1'b0;
              hold_d     = 1'b0;
              hold_cnt_d = '0;
              use_off_d  = 1'b0;
              idx_d      = '0;
              state_d    = ST_NEUT;
            end
            CMD_STATUS: begin
              mask_d      = '1;
              emit_kind_d = KIND_STATUS;
              done_d      = 1'b0;
              idx_d       = '0;
              state_d     = ST_EMIT;
            end
            default: ;  // drop unknown commands
          endcase
        end
      end

      ST_SCAN: begin
        cur_we         = 1'b1;
        mask_d[idx_q]  = alu_rsp.moved;
        all_at_d       = at_all;
        if (idx_q == CH_W'(CHANNELS - 1)) begin
          done_d = 1'b0;
          if (kick_q) begin
            if (hold_q) begin
              if (hold_cnt_q != '0) begin
                cnt_n = hold_cnt_q - HOLD_W'(1);
              end
            end else if (at_all) begin
              hold_n = 1'b1;
              cnt_n  = hold_ticks_q;
            end
            if (hold_n && (cnt_n == '0)) begin
              done_d = 1'b1;
              kick_d = 1'b0;
              hold_n = 1'b0;
            end
          end
          hold_d      = hold_n;
          hold_cnt_d  = cnt_n;
          emit_kind_d = KIND_PULSE;
          idx_d       = '0;
          if (mask_d != '0) begin
            state_d = ST_EMIT;
          end else if (done_d) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + CH_W'(1);
        end
      end

      ST_EMIT: begin
        // hold while a result is due and the output is still full
        if (!(mask_q[idx_q] && !can_load)) begin
          if (mask_q[idx_q]) begin
            out_load    = 1'b1;
            out_kind_d  = emit_kind_q;
            out_pw_d    = (emit_kind_q == KIND_PULSE) ? pulse : '0;
            out_pos_d   = cur_q[idx_q];
            out_last_d  = (above == '0) && !done_q;
          end
          if (above == '0) begin
            idx_d   = '0;
            state_d = done_q ? ST_DONE : ST_IDLE;
          end else begin
            idx_d = idx_q + CH_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (can_load) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_DONE;
          out_servo_d = '0;
          out_last_d  = 1'b1;
          done_d      = 1'b0;
          use_off_d   = 1'b0;
          idx_d       = '0;
          state_d     = ST_NEUT;
        end
      end

      ST_NEUT: begin
        tgt_we = 1'b1;
        if (idx_q == CH_W'(CHANNELS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CH_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      mask_q      <= '0;
      all_at_q    <= 1'b0;
      done_q      <= 1'b0;
      use_off_q   <= 1'b0;
      emit_kind_q <= KIND_PULSE;
      kick_q      <= 1'b0;
      hold_q      <= 1'b0;
      hold_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      all_at_q    <= all_at_d;
      done_q      <= done_d;
      use_off_q   <= use_off_d;
      emit_kind_q <= emit_kind_d;
      kick_q      <= kick_d;
      hold_q      <= hold_d;
      hold_cnt_q  <= hold_cnt_d;
    end
  end

  // angle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= NEUTRAL_RESET;
      tgt_q <= NEUTRAL_RESET;
    end else begin
      if (cur_we) begin
        cur_q[idx_q] <= alu_rsp.value;
      end
      if (tgt_we) begin
        tgt_q[tgt_idx] <= alu_rsp.value;
      end
    end
  end

  // pose offsets, captured on every command transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      off_q[0] <= in_offset_0_i;
      off_q[1] <= in_offset_1_i;
      off_q[2] <= in_offset_2_i;
      off_q[3] <= in_offset_3_i;
      off_q[4] <= in_offset_4_i;
      off_q[5] <= in_offset_5_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q    <= NEUTRAL_RESET;
      step_q       <= STEP_RESET;
      hold_ticks_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i < CFG_IDX_W'(CHANNELS)) begin
        neutral_q[cfg_index_i[CH_W-1:0]] <= cfg_wdata_i[ANGLE_W-1:0];
      end else if (cfg_index_i == REG_STEP_SIZE) begin
        step_q <= cfg_wdata_i[STEP_W-1:0];
      end else if (cfg_index_i == REG_HOLD_TICKS) begin
        hold_ticks_q <= cfg_wdata_i[HOLD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_servo_q <= out_servo_d;
      out_pw_q    <= out_pw_d;
      out_pos_q   <= out_pos_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_servo_o       = out_servo_q;
  assign out_pulse_width_o = out_pw_q;
  assign out_position_o    = out_pos_q;
  assign out_last_o        = out_last_q;

  `MSI_ASSERT_NOW(a_hold_needs_kick, hold_q, kick_q, "hold running without a kick")
  `MSI_ASSERT_NOW(a_done_is_last, out_valid_o && (out_kind_o == KIND_DONE), out_last_o && (out_position_o == '0), "kick done result is not a bare last result")
  `MSI_ASSERT_NOW(a_pulse_range, out_valid_o && (out_kind_o == KIND_PULSE), (out_pulse_width_o >= PULSE_LOW) && (out_pulse_width_o <= PULSE_HIGH), "pulse width out of range")
  `MSI_ASSERT_NOW(a_pos_range, out_valid_o, out_position_o <= ANGLE_MAX, "position beyond full scale")
  `MSI_ASSERT_NEXT(a_done_sweeps, (state_q == ST_DONE) && can_load, state_q == ST_NEUT, "kick done not followed by neutral sweep")

endmodule

`default_nettype wire
